// ===== src/four_level_page_table_mapper_assert.svh =====
// assertion macros for the four-level page table mapper
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define PGMAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PGMAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGMAP_ASSERT(lbl, prop, msg)
`define PGMAP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/pgmap_pkg.sv =====
// shared constants, types and microcode rom for the page table mapper
`timescale 1ns / 1ps
`default_nettype none
package pgmap_pkg;

  localparam int POOL_PAGES        = 16;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int PAGE_W            = $clog2(POOL_PAGES);
  localparam int NF_W              = $clog2(POOL_PAGES + 1);
  localparam int ADDR_W            = PAGE_W + IDX_W;
  localparam int DEPTH             = POOL_PAGES * ENTRIES_PER_TABLE;

  localparam int PAGE_OFS_W = 12;
  localparam int PFN_W      = 40;
  localparam int VA_W       = 48;
  localparam int PA_W       = 52;
  localparam int FLAG_W     = 12;
  localparam int ENT_W      = 52;
  localparam int VPN_W      = VA_W - PAGE_OFS_W;
  localparam int STATUS_W   = 2;
  localparam int ADDED_W    = 2;
  localparam int USED_W     = 5;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int STEP_W     = 4;

  localparam logic [ENT_W-1:0] BIT_PRESENT  = ENT_W'(1);
  localparam logic [ENT_W-1:0] BIT_WRITABLE = ENT_W'(2);
  localparam logic [PFN_W-1:0] POOL_BASE_RESET = PFN_W'(256);

  // register index as taken from paddr bit 3
  localparam logic REG_POOL_BASE = 1'b0;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    UOP_CLEAR,
    UOP_ACCEPT,
    UOP_READ,
    UOP_EVAL,
    UOP_LEAF,
    UOP_FIN
  } uop_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED    = 2'd0,
    ST_ROOT_ZERO = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  // level select: level n of the walk uses code n-1
  localparam logic [1:0] LVL_1 = 2'd0;
  localparam logic [1:0] LVL_2 = 2'd1;
  localparam logic [1:0] LVL_3 = 2'd2;
  localparam logic [1:0] LVL_4 = 2'd3;

  localparam step_t STEP_CLEAR  = 4'd0;
  localparam step_t STEP_ACCEPT = 4'd1;
  localparam step_t STEP_EVAL4  = 4'd2;
  localparam step_t STEP_READ3  = 4'd3;
  localparam step_t STEP_EVAL3  = 4'd4;
  localparam step_t STEP_READ2  = 4'd5;
  localparam step_t STEP_EVAL2  = 4'd6;
  localparam step_t STEP_LEAF   = 4'd7;
  localparam step_t STEP_FIN    = 4'd8;

  typedef struct packed {
    uop_t       op;
    logic [1:0] lvl;
    step_t      target;
  } ucw_t;

  typedef struct packed {
    logic hold;
    logic jump;
  } useq_cond_t;

  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    case (s)
      STEP_CLEAR:  w = '{op: UOP_CLEAR,  lvl: LVL_1, target: STEP_ACCEPT};
      STEP_ACCEPT: w = '{op: UOP_ACCEPT, lvl: LVL_4, target: STEP_FIN};
      STEP_EVAL4:  w = '{op: UOP_EVAL,   lvl: LVL_4, target: STEP_FIN};
      STEP_READ3:  w = '{op: UOP_READ,   lvl: LVL_3, target: STEP_FIN};
      STEP_EVAL3:  w = '{op: UOP_EVAL,   lvl: LVL_3, target: STEP_FIN};
      STEP_READ2:  w = '{op: UOP_READ,   lvl: LVL_2, target: STEP_FIN};
      STEP_EVAL2:  w = '{op: UOP_EVAL,   lvl: LVL_2, target: STEP_FIN};
      STEP_LEAF:   w = '{op: UOP_LEAF,   lvl: LVL_1, target: STEP_ACCEPT};
      STEP_FIN:    w = '{op: UOP_FIN,    lvl: LVL_1, target: STEP_ACCEPT};
      default:     w = '{op: UOP_FIN,    lvl: LVL_1, target: STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/pgmap_useq.sv =====
// microcode step counter and control word fetch
`timescale 1ns / 1ps
`default_nettype none
module pgmap_useq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pgmap_pkg::useq_cond_t cond,
  output pgmap_pkg::ucw_t            cw
);

  pgmap_pkg::step_t step_r;
  pgmap_pkg::step_t step_nxt;

  assign cw = pgmap_pkg::ucode(step_r);

  always_comb begin
    if (cond.hold) begin
      step_nxt = step_r;
    end else if (cond.jump) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + pgmap_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pgmap_pkg::STEP_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/four_level_page_table_mapper.sv =====
// four-level page table mapper: table pool memory, walk datapath, config and result registers
//
// Input channel in_*: one map request per item (virtual address, physical address, leaf flags).
// Result channel out_*: exactly one result item per request (status, leaf entry written,
// tables added by this request, pool pages in use).
// Config port (psel/penable/pwrite/paddr/pwdata/prdata/pready): one register, the
// pool base frame, where paddr bit 3 is low; pready is always high; reads return it or zero.
// A request is worked by a small microcode program against one single-port table memory:
// levels 4 to 2 each take a read step and an evaluate step (the level-4 read is issued at
// accept), then the leaf entry is written at level 1. A request that maps gives its result
// from the leaf step; a zero root frame, or a request that runs out of pool pages, jumps
// to the final step, which gives the result.
// After reset the table memory is cleared one entry a cycle, all 8192 entries, during which
// in_ready stays low; configuration writes are taken as usual.
// A result waits in the output register while out_ready is low; the next request is
// accepted meanwhile and its walk runs up to its last step, where it holds until the
// output register is free.
`timescale 1ns / 1ps
`default_nettype none
module four_level_page_table_mapper (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pgmap_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [pgmap_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [pgmap_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                     pready,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [pgmap_pkg::VA_W-1:0]          in_virt_addr,
  input  wire logic [pgmap_pkg::PA_W-1:0]          in_phys_addr,
  input  wire logic [pgmap_pkg::FLAG_W-1:0]        in_leaf_flags,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [pgmap_pkg::STATUS_W-1:0]      out_status,
  output logic      [pgmap_pkg::ENT_W-1:0]         out_leaf_entry,
  output logic      [pgmap_pkg::ADDED_W-1:0]       out_tables_added,
  output logic      [pgmap_pkg::USED_W-1:0]        out_pages_used
);

  `include "four_level_page_table_mapper_assert.svh"

  function automatic logic [pgmap_pkg::IDX_W-1:0] lvl_index(
    logic [pgmap_pkg::VPN_W-1:0] vpn,
    logic [1:0]                  lvl
  );
    logic [pgmap_pkg::IDX_W-1:0] idx;
    case (lvl)
      pgmap_pkg::LVL_1: idx = vpn[0 +: pgmap_pkg::IDX_W];
      pgmap_pkg::LVL_2: idx = vpn[pgmap_pkg::IDX_W +: pgmap_pkg::IDX_W];
      pgmap_pkg::LVL_3: idx = vpn[2*pgmap_pkg::IDX_W +: pgmap_pkg::IDX_W];
      pgmap_pkg::LVL_4: idx = vpn[3*pgmap_pkg::IDX_W +: pgmap_pkg::IDX_W];
      default:          idx = vpn[0 +: pgmap_pkg::IDX_W];
    endcase
    return idx;
  endfunction

  // sequencer
  pgmap_pkg::ucw_t       cw;
  pgmap_pkg::useq_cond_t cond;

  pgmap_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .cw    (cw)
  );

  // config register
  logic [pgmap_pkg::PFN_W-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= pgmap_pkg::POOL_BASE_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[3] == pgmap_pkg::REG_POOL_BASE) begin
      base_r <= pwdata[pgmap_pkg::PFN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == pgmap_pkg::REG_POOL_BASE) ?
                  pgmap_pkg::CFG_DATA_W'(base_r) : '0;

  // walk state
  logic [pgmap_pkg::VPN_W-1:0]                   vpn_r, vpn_nxt;
  logic [pgmap_pkg::PA_W-pgmap_pkg::PAGE_OFS_W-1:0] pfn_r, pfn_nxt;
  logic [pgmap_pkg::FLAG_W-1:0]                  flags_r, flags_nxt;
  logic [pgmap_pkg::PAGE_W-1:0]                  page_r, page_nxt;
  logic [pgmap_pkg::ADDED_W-1:0]                 added_r, added_nxt;
  pgmap_pkg::status_t                            status_r, status_nxt;
  logic [pgmap_pkg::NF_W-1:0]                    next_free_r, next_free_nxt;
  logic [pgmap_pkg::ADDR_W-1:0]                  clr_addr_r, clr_addr_nxt;

  // output register
  logic                                          out_valid_r, out_valid_nxt;
  pgmap_pkg::status_t                            out_status_r, out_status_nxt;
  logic [pgmap_pkg::ENT_W-1:0]                   out_leaf_entry_r, out_leaf_entry_nxt;
  logic [pgmap_pkg::ADDED_W-1:0]                 out_tables_added_r, out_tables_added_nxt;
  logic [pgmap_pkg::USED_W-1:0]                  out_pages_used_r, out_pages_used_nxt;

  // table memory
  logic [pgmap_pkg::ENT_W-1:0]  table_mem [pgmap_pkg::DEPTH];
  logic [pgmap_pkg::ENT_W-1:0]  rd_data_r;
  logic                         mem_we;
  logic                         mem_re;
  logic [pgmap_pkg::ADDR_W-1:0] mem_addr;
  logic [pgmap_pkg::ENT_W-1:0]  mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= table_mem[mem_addr];
    end
  end

  // datapath values
  logic [pgmap_pkg::ADDR_W-1:0] walk_addr;
  logic [pgmap_pkg::PFN_W-1:0]  fresh_frame;
  logic [pgmap_pkg::PFN_W-1:0]  rel_page;
  logic [pgmap_pkg::ENT_W-1:0]  link_entry;
  logic [pgmap_pkg::ENT_W-1:0]  leaf_entry;
  logic                         pool_full;
  logic                         out_free;

  assign walk_addr   = {page_r, lvl_index(vpn_r, cw.lvl)};
  assign fresh_frame = base_r + pgmap_pkg::PFN_W'(next_free_r);
  // frame of a present entry taken relative to the pool base, mod 2^40
  assign rel_page    = rd_data_r[pgmap_pkg::ENT_W-1:pgmap_pkg::PAGE_OFS_W] - base_r;
  assign link_entry  = {fresh_frame, pgmap_pkg::PAGE_OFS_W'(0)}
                       | pgmap_pkg::BIT_WRITABLE | pgmap_pkg::BIT_PRESENT;
  assign leaf_entry  = {pfn_r, flags_r} | pgmap_pkg::BIT_PRESENT;
  assign pool_full   = next_free_r >= pgmap_pkg::NF_W'(pgmap_pkg::POOL_PAGES);
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    cond                 = '0;
    mem_we               = 1'b0;
    mem_re               = 1'b0;
    mem_addr             = walk_addr;
    mem_wdata            = leaf_entry;
    in_ready             = 1'b0;
    vpn_nxt              = vpn_r;
    pfn_nxt              = pfn_r;
    flags_nxt            = flags_r;
    page_nxt             = page_r;
    added_nxt            = added_r;
    status_nxt           = status_r;
    next_free_nxt        = next_free_r;
    clr_addr_nxt         = clr_addr_r;
    out_valid_nxt        = out_valid_r && !out_ready;
    out_status_nxt       = out_status_r;
    out_leaf_entry_nxt   = out_leaf_entry_r;
    out_tables_added_nxt = out_tables_added_r;
    out_pages_used_nxt   = out_pages_used_r;

    case (cw.op)
      pgmap_pkg::UOP_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + pgmap_pkg::ADDR_W'(1);
        cond.hold    = !(&clr_addr_r);
      end
      pgmap_pkg::UOP_ACCEPT: begin
        in_ready  = 1'b1;
        cond.hold = !in_valid;
        if (in_valid) begin
          vpn_nxt   = in_virt_addr[pgmap_pkg::VA_W-1:pgmap_pkg::PAGE_OFS_W];
          pfn_nxt   = in_phys_addr[pgmap_pkg::PA_W-1:pgmap_pkg::PAGE_OFS_W];
          flags_nxt = in_leaf_flags;
          page_nxt  = '0;
          added_nxt = '0;
          if (base_r == '0) begin
            status_nxt = pgmap_pkg::ST_ROOT_ZERO;
            cond.jump  = 1'b1;
          end else begin
            status_nxt = pgmap_pkg::ST_MAPPED;
            mem_re     = 1'b1;
            mem_addr   = {pgmap_pkg::PAGE_W'(0),
                          lvl_index(in_virt_addr[pgmap_pkg::VA_W-1:pgmap_pkg::PAGE_OFS_W],
                                    pgmap_pkg::LVL_4)};
          end
        end
      end
      pgmap_pkg::UOP_READ: begin
        mem_re = 1'b1;
      end
      pgmap_pkg::UOP_EVAL: begin
        if (!rd_data_r[0]) begin
          // missing table: take the next pool page and link it, or fail if the pool is full
          if (pool_full) begin
            status_nxt = pgmap_pkg::ST_EXHAUSTED;
            cond.jump  = 1'b1;
          end else begin
            mem_we        = 1'b1;
            mem_wdata     = link_entry;
            next_free_nxt = next_free_r + pgmap_pkg::NF_W'(1);
            added_nxt     = added_r + pgmap_pkg::ADDED_W'(1);
            page_nxt      = next_free_r[pgmap_pkg::PAGE_W-1:0];
          end
        end else if (rel_page >= pgmap_pkg::PFN_W'(next_free_r)) begin
          // present entry that points outside the allocated pool
          status_nxt = pgmap_pkg::ST_EXHAUSTED;
          cond.jump  = 1'b1;
        end else begin
          page_nxt = rel_page[pgmap_pkg::PAGE_W-1:0];
        end
      end
      pgmap_pkg::UOP_LEAF: begin
        cond.hold = !out_free;
        if (out_free) begin
          mem_we               = 1'b1;
          mem_wdata            = leaf_entry;
          cond.jump            = 1'b1;
          out_valid_nxt        = 1'b1;
          out_status_nxt       = status_r;
          out_leaf_entry_nxt   = leaf_entry;
          out_tables_added_nxt = added_r;
          out_pages_used_nxt   = pgmap_pkg::USED_W'(next_free_r);
        end
      end
      pgmap_pkg::UOP_FIN: begin
        cond.hold = !out_free;
        if (out_free) begin
          cond.jump            = 1'b1;
          out_valid_nxt        = 1'b1;
          out_status_nxt       = status_r;
          out_leaf_entry_nxt   = '0;
          out_tables_added_nxt = added_r;
          out_pages_used_nxt   = pgmap_pkg::USED_W'(next_free_r);
        end
      end
      default: begin
        cond.jump = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= pgmap_pkg::NF_W'(1);
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      next_free_r <= next_free_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vpn_r              <= vpn_nxt;
    pfn_r              <= pfn_nxt;
    flags_r            <= flags_nxt;
    page_r             <= page_nxt;
    added_r            <= added_nxt;
    status_r           <= status_nxt;
    out_status_r       <= out_status_nxt;
    out_leaf_entry_r   <= out_leaf_entry_nxt;
    out_tables_added_r <= out_tables_added_nxt;
    out_pages_used_r   <= out_pages_used_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_leaf_entry   = out_leaf_entry_r;
  assign out_tables_added = out_tables_added_r;
  assign out_pages_used   = out_pages_used_r;

  // checks
  `PGMAP_ASSERT(a_mapped_leaf_present, out_valid_r && (out_status_r == pgmap_pkg::ST_MAPPED) |-> out_leaf_entry_r[0], "mapped result without present leaf")
  `PGMAP_ASSERT(a_fail_leaf_zero, out_valid_r && (out_status_r != pgmap_pkg::ST_MAPPED) |-> (out_leaf_entry_r == '0), "failed result with nonzero leaf")
  `PGMAP_ASSERT(a_alloc_only_in_eval, (cw.op != pgmap_pkg::UOP_EVAL) |=> (next_free_r == $past(next_free_r)), "pool page taken outside an evaluate step")
  `PGMAP_ASSERT_ALWAYS(a_reset_pool, (!rst_n) |=> (next_free_r == pgmap_pkg::NF_W'(1)), "pool count not back to root after reset")

endmodule
`default_nettype wire
